// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every rising edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== rtl/hsvrgb_pkg.sv =====
// ----------------------------------------------------------------------------
// hsvrgb_pkg
// Transaction types and arithmetic constants for the HSV to RGB converter.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

	// Input transaction: hue in degrees, saturation and value in percent
	typedef struct packed {
		logic [8:0] hue_degrees;
		logic [6:0] saturation_pct;
		logic [6:0] value_pct;
	} hsv_t;

	// Output transaction: 8-bit colour components
	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
	} rgb_t;

	localparam int unsigned HUE_MAX       = 360;
	localparam int unsigned PCT_MAX       = 100;
	localparam int unsigned HALF_SPAN     = 60;     // degrees per sector
	localparam int unsigned SPAN          = 120;    // degrees per primary span
	localparam int unsigned CHROMA_SCALE  = 60;     // C = S*V*60
	localparam int unsigned VALUE_SCALE   = 6000;   // V*6000 over 600000
	// floor(n*255/600000) = floor(n*17/40000); the reciprocal of 40000 is
	// rounded up at shift 38, exact for every n*17 up to 10200000
	localparam int unsigned RECIP_SHIFT   = 38;
	localparam int unsigned RECIP_K       = 6871948;
	localparam int unsigned NUM17_MAX     = 10200000;

endpackage

// ===== rtl/hsv_to_rgb_converter.sv =====
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// Five-stage pipelined conversion of an HSV colour into 8-bit RGB.
// ----------------------------------------------------------------------------
// The block takes one HSV transaction per clock while the output is ready and
// returns one RGB transaction for each, in order. It has five register stages:
// clamp and sector decode, saturation times value, chroma and secondary
// products, offset and component selection, and the reciprocal multiply that
// scales each component to 0..255. Each stage carries its own valid bit and
// loads whenever it is empty or the stage after it moves, so bubbles are
// squeezed out and a new transaction is taken while a result waits at the
// output, as long as some stage is free; once all five stages hold a
// transaction, the input stalls until the output side takes one. Inputs
// above range are clamped (hue to 360, percentages to 100); hue 360 falls in
// the last sector and gives the same colour as hue 0.
// Arithmetic is exact integer math over a denominator of 600000 and every
// component is floored. Reset clears the valid bits only.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              hsv_valid,
	output logic              hsv_ready,
	input  hsvrgb_pkg::hsv_t  hsv,
	output logic              rgb_valid,
	input  logic              rgb_ready,
	output hsvrgb_pkg::rgb_t  rgb
);
	import hsvrgb_pkg::*;

`include "assert_macros.svh"

	// 60-degree sectors, named by the order of (red, green, blue)
	typedef enum logic [2:0] {
		SEC_CX0 = 3'd0,
		SEC_XC0 = 3'd1,
		SEC_0CX = 3'd2,
		SEC_0XC = 3'd3,
		SEC_X0C = 3'd4,
		SEC_C0X = 3'd5
	} sector_t;

	localparam int unsigned NLANE = 3;

	// ------------------------------------------------------------------------
	// Stage enables: a stage loads when it is empty or its successor loads
	// ------------------------------------------------------------------------
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;

	assign en_s5     = !vld_s5 || rgb_ready;
	assign en_s4     = !vld_s4 || en_s5;
	assign en_s3     = !vld_s3 || en_s4;
	assign en_s2     = !vld_s2 || en_s3;
	assign en_s1     = !vld_s1 || en_s2;
	assign hsv_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= hsv_valid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2;
			if (en_s4) vld_s4 <= vld_s3;
			if (en_s5) vld_s5 <= vld_s4;
		end
	end

	// ------------------------------------------------------------------------
	// Stage 1: clamp, pick the sector and the secondary weight 60 - |t - 60|
	// ------------------------------------------------------------------------
	logic [8:0] hue_c;
	logic [6:0] sat_c, val_c;
	logic [6:0] hue_t;        // hue within its 120-degree span, 0..120
	logic [6:0] hue_dev;
	logic [5:0] weight;
	sector_t    sector_c;

	always_comb begin
		hue_c = (hsv.hue_degrees > 9'(HUE_MAX)) ? 9'(HUE_MAX) : hsv.hue_degrees;
		sat_c = (hsv.saturation_pct > 7'(PCT_MAX)) ? 7'(PCT_MAX) : hsv.saturation_pct;
		val_c = (hsv.value_pct > 7'(PCT_MAX)) ? 7'(PCT_MAX) : hsv.value_pct;

		// Hue 360 lands on t = 120, which gives the same zero weight as t = 0
		if (hue_c < 9'(SPAN))
			hue_t = hue_c[6:0];
		else if (hue_c < 9'(2 * SPAN))
			hue_t = 7'(hue_c - 9'(SPAN));
		else
			hue_t = 7'(hue_c - 9'(2 * SPAN));

		hue_dev = (hue_t >= 7'(HALF_SPAN)) ? (hue_t - 7'(HALF_SPAN))
		                                   : (7'(HALF_SPAN) - hue_t);
		weight  = 6'(7'(HALF_SPAN) - hue_dev);

		if (hue_c < 9'(HALF_SPAN))          sector_c = SEC_CX0;
		else if (hue_c < 9'(2 * HALF_SPAN)) sector_c = SEC_XC0;
		else if (hue_c < 9'(3 * HALF_SPAN)) sector_c = SEC_0CX;
		else if (hue_c < 9'(4 * HALF_SPAN)) sector_c = SEC_0XC;
		else if (hue_c < 9'(5 * HALF_SPAN)) sector_c = SEC_X0C;
		else                                sector_c = SEC_C0X;
	end

	logic [6:0] sat_s1, val_s1;
	logic [5:0] weight_s1;
	sector_t    sector_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			sat_s1    <= sat_c;
			val_s1    <= val_c;
			weight_s1 <= weight;
			sector_s1 <= sector_c;
		end
	end

	// ------------------------------------------------------------------------
	// Stage 2: saturation times value, at most 10000
	// ------------------------------------------------------------------------
	logic [13:0] sv_s2;
	logic [6:0]  val_s2;
	logic [5:0]  weight_s2;
	sector_t     sector_s2;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			sv_s2     <= 14'(sat_s1) * 14'(val_s1);
			val_s2    <= val_s1;
			weight_s2 <= weight_s1;
			sector_s2 <= sector_s1;
		end
	end

	// ------------------------------------------------------------------------
	// Stage 3: chroma, secondary and scaled value, each at most 600000
	// ------------------------------------------------------------------------
	logic [19:0] chroma_s3, second_s3, vscale_s3;
	sector_t     sector_s3;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			chroma_s3 <= 20'(sv_s2) * 20'(CHROMA_SCALE);
			second_s3 <= 20'(sv_s2) * 20'(weight_s2);
			vscale_s3 <= 20'(val_s2) * 20'(VALUE_SCALE);
			sector_s3 <= sector_s2;
		end
	end

	// ------------------------------------------------------------------------
	// Stage 4: place C, X and zero, add the floor offset, times 17
	// ------------------------------------------------------------------------
	logic [19:0] offset;
	logic [19:0] lane_raw [NLANE];
	logic [19:0] lane_sum [NLANE];
	logic [23:0] num17    [NLANE];

	always_comb begin
		// V*6000 >= S*V*60 always, so the offset never wraps
		offset = vscale_s3 - chroma_s3;
		unique case (sector_s3)
			SEC_CX0: begin
				lane_raw[0] = chroma_s3; lane_raw[1] = second_s3; lane_raw[2] = '0;
			end
			SEC_XC0: begin
				lane_raw[0] = second_s3; lane_raw[1] = chroma_s3; lane_raw[2] = '0;
			end
			SEC_0CX: begin
				lane_raw[0] = '0; lane_raw[1] = chroma_s3; lane_raw[2] = second_s3;
			end
			SEC_0XC: begin
				lane_raw[0] = '0; lane_raw[1] = second_s3; lane_raw[2] = chroma_s3;
			end
			SEC_X0C: begin
				lane_raw[0] = second_s3; lane_raw[1] = '0; lane_raw[2] = chroma_s3;
			end
			SEC_C0X: begin
				lane_raw[0] = chroma_s3; lane_raw[1] = '0; lane_raw[2] = second_s3;
			end
			default: begin
				lane_raw[0] = '0; lane_raw[1] = '0; lane_raw[2] = '0;
			end
		endcase
		for (int i = 0; i < NLANE; i++) begin
			lane_sum[i] = lane_raw[i] + offset;
			num17[i]    = {lane_sum[i], 4'b0000} + 24'(lane_sum[i]);
		end
	end

	logic [23:0] num17_s4 [NLANE];

	always_ff @(posedge clk) begin
		if (en_s4) begin
			for (int i = 0; i < NLANE; i++)
				num17_s4[i] <= num17[i];
		end
	end

	// ------------------------------------------------------------------------
	// Stage 5: divide by 40000 through the rounded-up reciprocal
	// ------------------------------------------------------------------------
	logic [46:0] prod [NLANE];
	logic [7:0]  byte_c [NLANE];

	always_comb begin
		for (int i = 0; i < NLANE; i++) begin
			prod[i]   = 47'(num17_s4[i]) * 47'(RECIP_K);
			byte_c[i] = prod[i][RECIP_SHIFT +: 8];
		end
	end

	rgb_t rgb_s5;

	always_ff @(posedge clk) begin
		if (en_s5) begin
			rgb_s5.red_out   <= byte_c[0];
			rgb_s5.green_out <= byte_c[1];
			rgb_s5.blue_out  <= byte_c[2];
		end
	end

	assign rgb_valid = vld_s5;
	assign rgb       = rgb_s5;

	// ------------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------------
	`ASSERT_IMPLIES(a_empty_front_ready, !vld_s1, hsv_ready,
		"input stalled although the first stage is empty")
	`ASSERT_IMPLIES(a_ready_ripples, rgb_ready, hsv_ready,
		"input stalled although the output side is ready")
	`ASSERT_IMPLIES(a_num_bound, vld_s4,
		(num17_s4[0] <= 24'(NUM17_MAX)) && (num17_s4[1] <= 24'(NUM17_MAX)) &&
		(num17_s4[2] <= 24'(NUM17_MAX)),
		"component numerator exceeds full scale")

endmodule

// ===== dv/hsv_to_rgb_converter_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_tb
// Self-checking bench for the HSV to RGB converter. A short table of corner
// colours runs first, then a long run of random colours. The sender idles in
// bursts and the receiver stalls on a rotating pattern. Every RGB result is
// compared field by field against an in-order queue of predicted colours.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_tb;

	import hsvrgb_pkg::*;

	localparam int unsigned RESET_CYCLES   = 12;
	localparam int unsigned RANDOM_ITEMS   = 1830;
	// Pipeline is five stages deep; allow a comfortable margin after the last
	// result before declaring the output quiet.
	localparam int unsigned DRAIN_CYCLES   = 24;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned MAX_REPORTED   = 10;
	localparam int unsigned FRACTION_DENOM = 600000;
	localparam int unsigned BYTE_SCALE     = 255;
	localparam int unsigned N_DIRECTED     = 23;

	// One row of the corner table: the colour to send and, where the answer is
	// plain to see, the RGB value typed in by hand.
	typedef struct {
		hsv_t colour;
		bit   hand_checked;
		rgb_t rgb_known;
	} corner_row_t;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic hsv_valid = 1'b0;
	hsv_t hsv       = '0;
	logic rgb_ready = 1'b0;
	logic hsv_ready;
	logic rgb_valid;
	rgb_t rgb;

	rgb_t        rgb_pending_q[$];
	int unsigned fault_count  = 0;
	int unsigned idle_cycles  = 0;
	int unsigned burst_left   = 0;
	logic [15:0] ready_pattern = 16'hFFFF;
	int unsigned pattern_age  = 0;

	// Sector edges, clamp points, black and white, and saturated primaries.
	corner_row_t corner_rows [N_DIRECTED] = '{
		'{'{9'd0,   7'd0,   7'd0  }, 1'b1, '{8'd0,   8'd0,   8'd0  }},
		'{'{9'd200, 7'd100, 7'd0  }, 1'b1, '{8'd0,   8'd0,   8'd0  }},
		'{'{9'd0,   7'd0,   7'd100}, 1'b1, '{8'd255, 8'd255, 8'd255}},
		'{'{9'd0,   7'd100, 7'd100}, 1'b1, '{8'd255, 8'd0,   8'd0  }},
		'{'{9'd60,  7'd100, 7'd100}, 1'b1, '{8'd255, 8'd255, 8'd0  }},
		'{'{9'd120, 7'd100, 7'd100}, 1'b1, '{8'd0,   8'd255, 8'd0  }},
		'{'{9'd180, 7'd100, 7'd100}, 1'b1, '{8'd0,   8'd255, 8'd255}},
		'{'{9'd240, 7'd100, 7'd100}, 1'b1, '{8'd0,   8'd0,   8'd255}},
		'{'{9'd300, 7'd100, 7'd100}, 1'b1, '{8'd255, 8'd0,   8'd255}},
		'{'{9'd359, 7'd100, 7'd100}, 1'b0, '0},
		'{'{9'd360, 7'd100, 7'd100}, 1'b1, '{8'd255, 8'd0,   8'd0  }},
		'{'{9'd361, 7'd100, 7'd100}, 1'b1, '{8'd255, 8'd0,   8'd0  }},
		'{'{9'd511, 7'd127, 7'd127}, 1'b1, '{8'd255, 8'd0,   8'd0  }},
		'{'{9'd90,  7'd127, 7'd100}, 1'b0, '0},
		'{'{9'd30,  7'd50,  7'd75 }, 1'b0, '0},
		'{'{9'd150, 7'd40,  7'd60 }, 1'b0, '0},
		'{'{9'd210, 7'd80,  7'd30 }, 1'b0, '0},
		'{'{9'd270, 7'd100, 7'd50 }, 1'b0, '0},
		'{'{9'd330, 7'd25,  7'd90 }, 1'b0, '0},
		'{'{9'd59,  7'd100, 7'd100}, 1'b0, '0},
		'{'{9'd1,   7'd1,   7'd1  }, 1'b0, '0},
		'{'{9'd100, 7'd64,  7'd127}, 1'b0, '0},
		'{'{9'd256, 7'd63,  7'd101}, 1'b0, '0}
	};

	hsv_to_rgb_converter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.hsv_valid (hsv_valid),
		.hsv_ready (hsv_ready),
		.hsv       (hsv),
		.rgb_valid (rgb_valid),
		.rgb_ready (rgb_ready),
		.rgb       (rgb)
	);

	always #1 clk = ~clk;

	// Scale a component numerator (over 600000) to a byte, rounding down.
	function automatic logic [7:0] to_byte(input int unsigned numer);
		return 8'((numer * BYTE_SCALE) / FRACTION_DENOM);
	endfunction

	// Predict the RGB colour for one HSV transaction.
	function automatic rgb_t rgb_from_hsv(input hsv_t px);
		int unsigned hue, sat, val, sv, chroma, second, floor_off, hue_dev, phase;
		int unsigned r, g, b;
		rgb_t        res;
		hue = (px.hue_degrees > HUE_MAX) ? HUE_MAX : px.hue_degrees;
		sat = (px.saturation_pct > PCT_MAX) ? PCT_MAX : px.saturation_pct;
		val = (px.value_pct > PCT_MAX) ? PCT_MAX : px.value_pct;
		sv        = sat * val;
		chroma    = sv * CHROMA_SCALE;
		phase     = hue % SPAN;
		hue_dev   = (phase >= HALF_SPAN) ? phase - HALF_SPAN : HALF_SPAN - phase;
		second    = sv * (HALF_SPAN - hue_dev);
		floor_off = val * VALUE_SCALE - chroma;
		// Hue 360 lands in the last sector, where the secondary is zero.
		if (hue < 60) begin
			r = chroma; g = second; b = 0;
		end else if (hue < 120) begin
			r = second; g = chroma; b = 0;
		end else if (hue < 180) begin
			r = 0; g = chroma; b = second;
		end else if (hue < 240) begin
			r = 0; g = second; b = chroma;
		end else if (hue < 300) begin
			r = second; g = 0; b = chroma;
		end else begin
			r = chroma; g = 0; b = second;
		end
		res.red_out   = to_byte(r + floor_off);
		res.green_out = to_byte(g + floor_off);
		res.blue_out  = to_byte(b + floor_off);
		return res;
	endfunction

	// Percentage with extra weight on the two ends of the range.
	function automatic logic [6:0] random_pct();
		if ($urandom_range(0, 7) == 0) begin
			return $urandom_range(0, 1) ? 7'(PCT_MAX) : 7'd0;
		end
		return 7'($urandom_range(0, PCT_MAX));
	endfunction

	function automatic hsv_t random_colour();
		hsv_t px;
		int   hue;
		case ($urandom_range(0, 9))
			0: begin
				// Full field width, so clamping gets exercised.
				px.hue_degrees    = 9'($urandom);
				px.saturation_pct = 7'($urandom);
				px.value_pct      = 7'($urandom);
			end
			1, 2: begin
				// Hug a sector boundary.
				hue = 60 * $urandom_range(0, 6) + $urandom_range(0, 2) - 1;
				if (hue < 0) begin
					hue = 0;
				end
				px.hue_degrees    = 9'(hue);
				px.saturation_pct = random_pct();
				px.value_pct      = random_pct();
			end
			default: begin
				px.hue_degrees    = 9'($urandom_range(0, HUE_MAX));
				px.saturation_pct = random_pct();
				px.value_pct      = random_pct();
			end
		endcase
		return px;
	endfunction

	task automatic report_fault(input string msg);
		fault_count++;
		if (fault_count <= MAX_REPORTED) begin
			$display("[%0t] %s", $realtime, msg);
		end
	endtask

	// Send one HSV transaction and log its expected colour once accepted.
	// The sender runs in bursts; between bursts it may drop valid for a while.
	task automatic send_colour(input hsv_t px, input bit hand_checked,
			input rgb_t rgb_known);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
			if (gap > 0) begin
				hsv_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		hsv       <= px;
		hsv_valid <= 1'b1;
		@(posedge clk);
		while (!hsv_ready) @(posedge clk);
		rgb_pending_q.push_back(hand_checked ? rgb_known : rgb_from_hsv(px));
	endtask

	// Receiver: check each accepted RGB transaction, then advance the stall
	// pattern. The pattern is reloaded now and then with a fresh character:
	// never stalling, mostly ready, mostly stalled or plain random.
	always @(posedge clk) begin
		rgb_t want;
		if (arst_n && rgb_valid && rgb_ready) begin
			if (rgb_pending_q.size() == 0) begin
				report_fault($sformatf("unexpected RGB transaction %0d/%0d/%0d",
					rgb.red_out, rgb.green_out, rgb.blue_out));
			end else begin
				want = rgb_pending_q.pop_front();
				if (rgb.red_out !== want.red_out || rgb.green_out !== want.green_out
						|| rgb.blue_out !== want.blue_out) begin
					report_fault($sformatf("RGB mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
						want.red_out, want.green_out, want.blue_out,
						rgb.red_out, rgb.green_out, rgb.blue_out));
				end
			end
		end
		if (pattern_age == 63) begin
			case ($urandom_range(0, 3))
				0:       ready_pattern <= 16'hFFFF;
				1:       ready_pattern <= 16'($urandom | $urandom);
				2:       ready_pattern <= 16'($urandom & $urandom);
				default: ready_pattern <= 16'($urandom);
			endcase
			pattern_age <= 0;
		end else begin
			ready_pattern <= {ready_pattern[14:0], ready_pattern[15]};
			pattern_age   <= pattern_age + 1;
		end
		rgb_ready <= ready_pattern[15];
	end

	// Watchdog: end the run if neither side moves a transaction for too long.
	always @(posedge clk) begin
		if ((hsv_valid && hsv_ready) || (rgb_valid && rgb_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("watchdog expired with %0d colours outstanding", rgb_pending_q.size());
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (corner_rows[i]) begin
			send_colour(corner_rows[i].colour, corner_rows[i].hand_checked,
				corner_rows[i].rgb_known);
		end
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			send_colour(random_colour(), 1'b0, '0);
		end
		hsv_valid <= 1'b0;

		// Hold until every colour has come back, then let the pipe run dry.
		while (rgb_pending_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (rgb_pending_q.size() != 0) begin
			report_fault($sformatf("%0d colours never returned", rgb_pending_q.size()));
		end

		if (fault_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/hsvrgb_pkg.sv
rtl/hsv_to_rgb_converter.sv
dv/hsv_to_rgb_converter_tb.sv
